[sv/mub_pkg.sv]
// constants and fixed-point helpers for the mask uncertainty blend
package mub_pkg;

    localparam int RATIO_W  = 17;
    localparam int INDEX_W  = 16;
    localparam int X_W      = 15;
    localparam int ACC_W    = 32;
    localparam int MPROD_W  = 48;
    localparam int FRAC_ONE = 65536;

    // polynomial coefficients, signed with 16 fraction bits
    localparam logic signed [ACC_W-1:0] COEF_1 = 32'sd372796;
    localparam logic signed [ACC_W-1:0] COEF_2 = -32'sd49067;
    localparam logic signed [ACC_W-1:0] COEF_3 = -32'sd3788315;
    localparam logic signed [ACC_W-1:0] COEF_4 = 32'sd19091227;
    localparam logic signed [ACC_W-1:0] COEF_5 = -32'sd40941453;

    // acc * x / 2^16, rounded half up
    function automatic logic signed [ACC_W-1:0] mul_round16(
        input logic signed [ACC_W-1:0] acc,
        input logic [X_W-1:0]          x
    );
        logic signed [X_W:0]       xs;
        logic signed [MPROD_W-1:0] prod;
        logic signed [MPROD_W-1:0] rnd;
        begin
            xs   = signed'({1'b0, x});
            prod = acc * xs;
            rnd  = prod + 48'sd32768;
            return ACC_W'(rnd >>> 16);
        end
    endfunction

endpackage

[sv/mask_uncertainty_blend.sv]
// top level: pipelined uncertainty-weighted temporal blend of a mask stream
// Takes one mask pixel per clock while in_stall is low and returns one blended pixel per
// transaction. The pipeline holds up to ten pixels in flight: nine stages (squaring,
// rounding to x, four Horner multiply stages, the uncertainty stage, the weight multiply
// with the frame store read, and the final blend) plus the output register.
// The frame store is a single memory with one read and one write per clock; a pixel that
// hits the same index as a pixel just ahead of it gets that pixel's result by forwarding.
// A stall on the output freezes the whole pipeline; items are never dropped or repeated.
// The user writes blend_ratio only while idle, unchecked; values over 1.0 saturate to 1.0.
module mask_uncertainty_blend
    import mub_pkg::*;
#(
    parameter int MASK_PIXELS = 65536,
    parameter int VALUE_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  blend_ratio_we,
    input  logic [RATIO_W-1:0]    blend_ratio,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] new_mask,
    input  logic [INDEX_W-1:0]    pixel_index,
    input  logic                  first_frame,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] blended_mask,
    output logic [INDEX_W-1:0]    out_index
);

    localparam int DEPTH    = (MASK_PIXELS > 65536) ? 65536 : MASK_PIXELS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NSTAGE   = 9;
    localparam int SQ_W     = 2 * VALUE_BITS;
    localparam int SQ_SHIFT = 2 * VALUE_BITS - 16;
    localparam int BPROD_W  = VALUE_BITS + 19;
    localparam int R_W      = VALUE_BITS + 2;

    localparam logic [VALUE_BITS-1:0] HALF = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic adv;

    logic                  valid_reg  [1:NSTAGE];
    logic [VALUE_BITS-1:0] p_reg      [1:NSTAGE];
    logic [INDEX_W-1:0]    idx_reg    [1:NSTAGE];
    logic                  first_reg  [1:NSTAGE];
    logic                  inside_reg [1:NSTAGE];

    logic [SQ_W-1:0]         sq_reg;
    logic [X_W-1:0]          x_reg   [3:7];
    logic signed [ACC_W-1:0] acc_reg [4:7];
    logic [RATIO_W-1:0]      u_reg;
    logic [RATIO_W-1:0]      w_reg;
    logic [VALUE_BITS-1:0]   prev_reg;
    logic                    fwd_reg;
    logic [VALUE_BITS-1:0]   mem_rd_reg;

    logic [RATIO_W-1:0]    blend_ratio_reg;
    logic                  out_valid_reg;
    logic                  wr_last_reg;
    logic [VALUE_BITS-1:0] blended_mask_reg;
    logic [INDEX_W-1:0]    out_index_reg;

    logic [VALUE_BITS-1:0] mem [DEPTH];

    logic                    inside_in;
    logic [VALUE_BITS-1:0]   abs_t;
    logic [SQ_W-1:0]         sq_next;
    logic [X_W-1:0]          x_next;
    logic signed [ACC_W-1:0] acc4_next;
    logic signed [ACC_W-1:0] acc3_next;
    logic signed [ACC_W-1:0] acc2_next;
    logic signed [ACC_W-1:0] acc1_next;
    logic signed [ACC_W-1:0] poly;
    logic [RATIO_W-1:0]      u_next;
    logic [33:0]             wprod;
    logic [RATIO_W-1:0]      w_next;
    logic [VALUE_BITS-1:0]   prev_next;
    logic                    fwd_next;
    logic [VALUE_BITS-1:0]   prev_sel;
    logic signed [VALUE_BITS:0] diff;
    logic signed [BPROD_W-1:0]  bprod;
    logic signed [BPROD_W-1:0]  brnd;
    logic signed [R_W-1:0]      r_full;
    logic [VALUE_BITS-1:0]   blended_next;
    logic                    mem_we;

    // whole pipeline moves unless a finished result is held by the receiver
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    assign out_valid    = out_valid_reg;
    assign blended_mask = blended_mask_reg;
    assign out_index    = out_index_reg;

    assign inside_in = (32'(pixel_index) < 32'(DEPTH));

    // stage 1: |p - 0.5| squared
    always_comb
    begin
        if (p_reg[1][VALUE_BITS-1])
        begin
            abs_t = p_reg[1] - HALF;
        end
        else
        begin
            abs_t = HALF - p_reg[1];
        end
        sq_next = SQ_W'(abs_t) * SQ_W'(abs_t);
    end

    // stage 2: round square to unsigned q0.16
    generate
        if (SQ_SHIFT > 0)
        begin : g_xround
            localparam logic [SQ_W-1:0] SQ_RND = SQ_W'(1) << (SQ_SHIFT - 1);
            logic [SQ_W-1:0] sq_rnd;
            assign sq_rnd = (sq_reg + SQ_RND) >> SQ_SHIFT;
            assign x_next = sq_rnd[X_W-1:0];
        end
        else
        begin : g_xplain
            assign x_next = sq_reg[X_W-1:0];
        end
    endgenerate

    // stages 3 to 7: horner steps, then the final product
    assign acc4_next = COEF_4 + mul_round16(COEF_5, x_reg[3]);
    assign acc3_next = COEF_3 + mul_round16(acc_reg[4], x_reg[4]);
    assign acc2_next = COEF_2 + mul_round16(acc_reg[5], x_reg[5]);
    assign acc1_next = COEF_1 + mul_round16(acc_reg[6], x_reg[6]);
    assign poly      = mul_round16(acc_reg[7], x_reg[7]);

    always_comb
    begin
        if (poly >= 32'sd65536)
        begin
            u_next = '0;
        end
        else if (poly <= 32'sd0)
        begin
            u_next = RATIO_W'(FRAC_ONE);
        end
        else
        begin
            u_next = RATIO_W'(32'(FRAC_ONE) - poly);
        end
    end

    // stage 8: weight and previous value, with forwarding from the two items ahead
    assign wprod  = 34'(u_reg) * 34'(blend_ratio_reg);
    assign w_next = RATIO_W'((wprod + 34'd32768) >> 16);

    always_comb
    begin
        if (wr_last_reg && (out_index_reg == idx_reg[8]))
        begin
            prev_next = blended_mask_reg;
        end
        else
        begin
            prev_next = mem_rd_reg;
        end
        fwd_next = valid_reg[9] && inside_reg[9] && (idx_reg[9] == idx_reg[8]);
    end

    // stage 9: blend and clamp
    always_comb
    begin
        if (first_reg[9] || !inside_reg[9])
        begin
            prev_sel = p_reg[9];
        end
        else if (fwd_reg)
        begin
            prev_sel = blended_mask_reg;
        end
        else
        begin
            prev_sel = prev_reg;
        end
        diff   = signed'({1'b0, prev_sel}) - signed'({1'b0, p_reg[9]});
        bprod  = diff * signed'({1'b0, w_reg});
        brnd   = (bprod + BPROD_W'(32768)) >>> 16;
        r_full = signed'({2'b00, p_reg[9]}) + R_W'(brnd);
        if (r_full < 0)
        begin
            blended_next = '0;
        end
        else if (r_full > signed'({2'b00, {VALUE_BITS{1'b1}}}))
        begin
            blended_next = {VALUE_BITS{1'b1}};
        end
        else
        begin
            blended_next = r_full[VALUE_BITS-1:0];
        end
    end

    assign mem_we = adv && valid_reg[9] && inside_reg[9];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_ratio_reg <= '0;
            out_valid_reg   <= 1'b0;
            wr_last_reg     <= 1'b0;
            for (int i = 1; i <= NSTAGE; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (blend_ratio_we)
            begin
                blend_ratio_reg <= (blend_ratio > RATIO_W'(FRAC_ONE)) ?
                                   RATIO_W'(FRAC_ONE) : blend_ratio;
            end
            if (adv)
            begin
                valid_reg[1] <= in_valid;
                for (int i = 2; i <= NSTAGE; i++)
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
                out_valid_reg <= valid_reg[NSTAGE];
                wr_last_reg   <= valid_reg[NSTAGE] && inside_reg[NSTAGE];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[1]      <= new_mask;
            idx_reg[1]    <= pixel_index;
            first_reg[1]  <= first_frame;
            inside_reg[1] <= inside_in;
            for (int i = 2; i <= NSTAGE; i++)
            begin
                p_reg[i]      <= p_reg[i-1];
                idx_reg[i]    <= idx_reg[i-1];
                first_reg[i]  <= first_reg[i-1];
                inside_reg[i] <= inside_reg[i-1];
            end
            sq_reg   <= sq_next;
            x_reg[3] <= x_next;
            for (int i = 4; i <= 7; i++)
            begin
                x_reg[i] <= x_reg[i-1];
            end
            acc_reg[4] <= acc4_next;
            acc_reg[5] <= acc3_next;
            acc_reg[6] <= acc2_next;
            acc_reg[7] <= acc1_next;
            u_reg      <= u_next;
            w_reg      <= w_next;
            prev_reg   <= prev_next;
            fwd_reg    <= fwd_next;
            blended_mask_reg <= blended_next;
            out_index_reg    <= idx_reg[NSTAGE];
        end
    end

    // previous-frame store, read ahead of stage 8, written from stage 9
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg[NSTAGE][ADDR_W-1:0]] <= blended_next;
        end
        if (adv)
        begin
            mem_rd_reg <= mem[idx_reg[7][ADDR_W-1:0]];
        end
    end

endmodule

[sim/mask_uncertainty_blend_test.sv]
// self-checking testbench for the mask uncertainty blend pipeline
`timescale 1ns / 100ps

module mask_uncertainty_blend_test;

    import mub_pkg::RATIO_W;
    import mub_pkg::INDEX_W;

    localparam int VBITS       = 16;
    localparam int PIPE_LAT    = 12;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 300;
    localparam int NUM_PHASES  = 6;
    localparam int NO_WRITE    = -1;
    localparam int DIR_ROWS    = 22;

    localparam longint HALF_Q16  = 32768;
    localparam longint ONE_Q16   = 65536;
    localparam longint HORNER_C1 = 372796;
    localparam longint HORNER_C2 = -49067;
    localparam longint HORNER_C3 = -3788315;
    localparam longint HORNER_C4 = 19091227;
    localparam longint HORNER_C5 = -40941453;

    typedef struct packed {
        logic [VBITS-1:0]   mask;
        logic [INDEX_W-1:0] idx;
    } blend_res_t;

    typedef struct {
        int                 ratio;
        logic [VBITS-1:0]   mask;
        logic [INDEX_W-1:0] idx;
        logic               first;
        bit                 typed;
        logic [VBITS-1:0]   want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               blend_ratio_we;
    logic [RATIO_W-1:0] blend_ratio;
    logic               in_valid;
    logic               in_stall;
    logic [VBITS-1:0]   new_mask;
    logic [INDEX_W-1:0] pixel_index;
    logic               first_frame;
    logic               out_valid;
    logic               out_stall;
    logic [VBITS-1:0]   blended_mask;
    logic [INDEX_W-1:0] out_index;

    // predictor state
    logic [VBITS-1:0]   prev_mask [0:65535];
    bit                 written_map [0:65535];
    logic [RATIO_W-1:0] ratio_q;
    blend_res_t         pending_px [$];
    blend_res_t         head_px;
    int                 seen_q [$];
    logic [INDEX_W-1:0] recent_idx [0:3];
    int                 mismatch_cnt = 0;
    bit                 gaps_on = 1'b1;
    bit                 hold_req = 1'b0;

    // ratio column: reset value, full weight, saturating value, half weight
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{NO_WRITE, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000},
        '{NO_WRITE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
        '{NO_WRITE, 16'h8000, 16'h0001, 1'b1, 1'b1, 16'h8000},
        '{NO_WRITE, 16'h7FFF, 16'h0002, 1'b1, 1'b1, 16'h7FFF},
        '{NO_WRITE, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 16'hFFFF},
        '{NO_WRITE, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 16'h0000},
        '{NO_WRITE, 16'h5555, 16'hAAAA, 1'b1, 1'b1, 16'h5555},
        '{NO_WRITE, 16'hAAAA, 16'h5555, 1'b1, 1'b1, 16'hAAAA},
        '{65536,    16'h8000, 16'h0000, 1'b0, 1'b0, 16'h0000},
        '{NO_WRITE, 16'h8000, 16'h0000, 1'b0, 1'b0, 16'h0000},
        '{NO_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
        '{NO_WRITE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{NO_WRITE, 16'h7FFF, 16'h0002, 1'b0, 1'b0, 16'h0000},
        '{NO_WRITE, 16'h1234, 16'h0003, 1'b1, 1'b1, 16'h1234},
        '{NO_WRITE, 16'h4000, 16'h0003, 1'b0, 1'b0, 16'h0000},
        '{131071,   16'h8000, 16'hAAAA, 1'b0, 1'b0, 16'h0000},
        '{NO_WRITE, 16'hC000, 16'hAAAA, 1'b0, 1'b0, 16'h0000},
        '{NO_WRITE, 16'h8001, 16'h5555, 1'b0, 1'b0, 16'h0000},
        '{NO_WRITE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
        '{NO_WRITE, 16'h0001, 16'h0001, 1'b0, 1'b0, 16'h0000},
        '{32768,    16'h6000, 16'h0001, 1'b0, 1'b0, 16'h0000},
        '{NO_WRITE, 16'hA000, 16'h0002, 1'b0, 1'b0, 16'h0000}
    };

    mask_uncertainty_blend #(
        .MASK_PIXELS (65536),
        .VALUE_BITS  (VBITS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .blend_ratio_we (blend_ratio_we),
        .blend_ratio    (blend_ratio),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .new_mask       (new_mask),
        .pixel_index    (pixel_index),
        .first_frame    (first_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .blended_mask   (blended_mask),
        .out_index      (out_index)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // floor(v / 2^16 + 1/2)
    function automatic longint rnd16(input longint v);
        return (v + HALF_Q16) >>> 16;
    endfunction

    function automatic logic [VBITS-1:0] blend_pixel(
        input logic [VBITS-1:0]   p,
        input logic [VBITS-1:0]   prev,
        input logic [RATIO_W-1:0] ratio
    );
        longint t;
        longint x;
        longint acc;
        longint poly;
        longint u;
        longint rat;
        longint w;
        longint r;
        begin
            t    = longint'(p) - HALF_Q16;
            x    = (t * t + HALF_Q16) >>> 16;
            acc  = HORNER_C5;
            acc  = HORNER_C4 + rnd16(acc * x);
            acc  = HORNER_C3 + rnd16(acc * x);
            acc  = HORNER_C2 + rnd16(acc * x);
            acc  = HORNER_C1 + rnd16(acc * x);
            poly = rnd16(acc * x);
            if (poly > ONE_Q16)
                poly = ONE_Q16;
            u = ONE_Q16 - poly;
            if (u < 0)
                u = 0;
            if (u > ONE_Q16)
                u = ONE_Q16;
            rat = (longint'(ratio) > ONE_Q16) ? ONE_Q16 : longint'(ratio);
            w   = (u * rat + HALF_Q16) >>> 16;
            r   = longint'(p) + rnd16((longint'(prev) - longint'(p)) * w);
            if (r < 0)
                r = 0;
            if (r > 65535)
                r = 65535;
            return r[VBITS-1:0];
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_cnt++;
    endtask

    // offers one pixel and books its expected result once the transaction is taken
    task automatic push_pixel(
        input logic [VBITS-1:0]   mask,
        input logic [INDEX_W-1:0] idx,
        input logic               first,
        input bit                 typed,
        input logic [VBITS-1:0]   want
    );
        logic [VBITS-1:0] prev;
        logic [VBITS-1:0] res;
        blend_res_t       exp_px;
        begin
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            in_valid    <= 1'b1;
            new_mask    <= mask;
            pixel_index <= idx;
            first_frame <= first;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            prev = first ? mask : prev_mask[idx];
            res  = blend_pixel(mask, prev, ratio_q);
            prev_mask[idx] = res;
            if (!written_map[idx])
            begin
                written_map[idx] = 1'b1;
                seen_q = {seen_q, int'(idx)};
            end
            recent_idx[3] = recent_idx[2];
            recent_idx[2] = recent_idx[1];
            recent_idx[1] = recent_idx[0];
            recent_idx[0] = idx;
            exp_px.mask = typed ? want : res;
            exp_px.idx  = idx;
            pending_px  = {pending_px, exp_px};
        end
    endtask

    // register write with the pipeline drained
    task automatic set_ratio(input logic [RATIO_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
        blend_ratio_we <= 1'b1;
        blend_ratio    <= val;
        @(posedge clk);
        blend_ratio_we <= 1'b0;
        ratio_q = val;
    endtask

    // result side: random stall bursts plus one long hold-off
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_px.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result idx %h mask %h",
                    out_index, blended_mask));
            end
            else
            begin
                head_px = pending_px.pop_front();
                if (out_index !== head_px.idx)
                    report_mismatch($sformatf("out_index %h, want %h",
                        out_index, head_px.idx));
                if (blended_mask !== head_px.mask)
                    report_mismatch($sformatf("blended_mask %h, want %h (idx %h)",
                        blended_mask, head_px.mask, head_px.idx));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("mask_uncertainty_blend test failed");
        $finish;
    end

    initial
    begin
        int                 ph;
        int                 n;
        int                 pick;
        int                 ratio_plan [0:NUM_PHASES-1];
        logic [VBITS-1:0]   mask;
        logic [INDEX_W-1:0] idx;
        logic               first;

        rst_n          = 1'b0;
        blend_ratio_we = 1'b0;
        blend_ratio    = '0;
        in_valid       = 1'b0;
        new_mask       = '0;
        pixel_index    = '0;
        first_frame    = 1'b0;
        ratio_q        = '0;
        for (n = 0; n < 65536; n++)
        begin
            prev_mask[n]   = '0;
            written_map[n] = 1'b0;
        end
        for (n = 0; n < 4; n++)
            recent_idx[n] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (n = 0; n < DIR_ROWS; n++)
        begin
            if (dir_tab[n].ratio != NO_WRITE)
                set_ratio(RATIO_W'(dir_tab[n].ratio));
            push_pixel(dir_tab[n].mask, dir_tab[n].idx, dir_tab[n].first,
                dir_tab[n].typed, dir_tab[n].want);
        end

        ratio_plan[0] = $urandom_range(0, 65536);
        ratio_plan[1] = 65536;
        ratio_plan[2] = $urandom_range(1, 65535);
        ratio_plan[3] = $urandom_range(65537, 131071);
        ratio_plan[4] = 0;
        ratio_plan[5] = $urandom_range(0, 131071);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_ratio(RATIO_W'(ratio_plan[ph]));
            gaps_on = (ph != NUM_PHASES - 1);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // stall the results long enough to back up into the input
                if (ph == 1 && n == 100)
                    hold_req = 1'b1;
                case ($urandom_range(0, 12))
                    0:       mask = 16'h0000;
                    1:       mask = 16'hFFFF;
                    2:       mask = 16'h8000;
                    3:       mask = VBITS'(32640 + $urandom_range(0, 255));
                    default: mask = VBITS'($urandom_range(0, 65535));
                endcase
                pick = $urandom_range(0, 99);
                if (seen_q.size() == 0 || pick < 15)
                begin
                    first = 1'b1;
                    idx   = INDEX_W'($urandom_range(0, 65535));
                end
                else if (pick < 20)
                begin
                    first = 1'b1;
                    idx   = recent_idx[0];
                end
                else if (pick < 45)
                begin
                    // same pixel as the one just ahead
                    first = 1'b0;
                    idx   = recent_idx[0];
                end
                else if (pick < 60)
                begin
                    first = 1'b0;
                    idx   = recent_idx[$urandom_range(1, 3)];
                end
                else
                begin
                    first = 1'b0;
                    idx   = INDEX_W'(seen_q[$urandom_range(0, seen_q.size() - 1)]);
                end
                push_pixel(mask, idx, first, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT * 2) @(posedge clk);
        if (pending_px.size() != 0)
            report_mismatch("results still outstanding at end of run");
        if (mismatch_cnt == 0)
            $display("mask_uncertainty_blend test passed");
        else
            $display("mask_uncertainty_blend test failed");
        $finish;
    end

endmodule
